// File: rtl/csfw_pkg.sv
// Shared types for the counting semaphore with FIFO wait queue.
package csfw_pkg;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_WOKEN     = 3'd3,
        ST_RAISED    = 3'd4,
        ST_FULL      = 3'd5,
        ST_SATURATED = 3'd6
    } t_status;

    typedef enum logic {
        CMD_DOWN = 1'b0,
        CMD_UP   = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WAKE = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    localparam int CFG_BITS = 8;

endpackage

// File: rtl/csfw_wait_mem.sv
// Wait queue storage: one write port, one registered read port.
module csfw_wait_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/csfw_ctrl.sv
// Sequencer, count and queue pointers, and the single duplicate-compare unit.
module csfw_ctrl
    import csfw_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8,
    parameter int COUNT_BITS     = 8,
    localparam int PTR_W = $clog2(QUEUE_DEPTH),
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_cmd,
    input  logic [THREAD_ID_BITS-1:0] i_requester_thread,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_BITS-1:0]       i_cfg_initial_count,
    input  logic                      i_out_free,
    output logic                      o_done,
    output t_status                   o_status,
    output logic [THREAD_ID_BITS-1:0] o_woken_thread,
    output logic [COUNT_BITS-1:0]     o_count_now,
    output logic [OCC_W-1:0]          o_waiters_now,
    output logic                      o_mem_we,
    output logic [PTR_W-1:0]          o_mem_waddr,
    output logic [THREAD_ID_BITS-1:0] o_mem_wdata,
    output logic [PTR_W-1:0]          o_mem_raddr,
    input  logic [THREAD_ID_BITS-1:0] i_mem_rdata
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    t_state                    r_state, n_state;
    logic [COUNT_BITS-1:0]     r_count, n_count;
    logic [PTR_W-1:0]          r_head, n_head;
    logic [PTR_W-1:0]          r_tail, n_tail;
    logic [OCC_W-1:0]          r_occ, n_occ;
    logic [PTR_W-1:0]          r_ptr, n_ptr;
    logic [OCC_W-1:0]          r_iss, n_iss;
    logic                      r_pend, n_pend;
    logic [THREAD_ID_BITS-1:0] r_tid, n_tid;
    t_status                   r_status, n_status;
    logic [THREAD_ID_BITS-1:0] r_woken, n_woken;
    logic [COUNT_BITS-1:0]     cfg_count;
    logic                      in_acc;
    logic                      cfg_acc;
    logic                      issue;
    logic                      idle;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    generate
        if (COUNT_BITS >= CFG_BITS) begin : g_cfg_wide
            assign cfg_count = COUNT_BITS'(i_cfg_initial_count);
        end else begin : g_cfg_cap
            assign cfg_count = (|i_cfg_initial_count[CFG_BITS-1:COUNT_BITS]) ? CNT_MAX
                             : i_cfg_initial_count[COUNT_BITS-1:0];
        end
    endgenerate

    assign idle        = (r_state == S_IDLE);
    assign o_cfg_ready = idle;
    assign cfg_acc     = i_cfg_valid & idle;
    assign o_in_stall  = ~idle | i_cfg_valid;
    assign in_acc      = i_in_valid & ~o_in_stall;
    assign issue       = (r_iss != r_occ);
    assign o_mem_raddr = (r_state == S_SCAN) ? r_ptr : r_head;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_ptr       = r_ptr;
        n_iss       = r_iss;
        n_pend      = r_pend;
        n_tid       = r_tid;
        n_status    = r_status;
        n_woken     = r_woken;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_tail;
        o_mem_wdata = r_tid;
        unique case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    n_count = cfg_count;
                    n_head  = '0;
                    n_tail  = '0;
                    n_occ   = '0;
                end else if (in_acc) begin
                    n_tid   = i_requester_thread;
                    n_woken = '0;
                    if (t_cmd'(i_cmd) == CMD_DOWN) begin
                        if (r_count != '0) begin
                            n_count  = r_count - 1'b1;
                            n_status = ST_GRANTED;
                            n_state  = S_DONE;
                        end else if (r_occ == '0) begin
                            o_mem_we    = 1'b1;
                            o_mem_wdata = i_requester_thread;
                            n_tail      = f_next(r_tail);
                            n_occ       = r_occ + 1'b1;
                            n_status    = ST_QUEUED;
                            n_state     = S_DONE;
                        end else begin
                            n_ptr   = r_head;
                            n_iss   = '0;
                            n_pend  = 1'b0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (r_occ != '0) begin
                            n_state = S_WAKE;
                        end else if (r_count == CNT_MAX) begin
                            n_status = ST_SATURATED;
                            n_state  = S_DONE;
                        end else begin
                            n_count  = r_count + 1'b1;
                            n_status = ST_RAISED;
                            n_state  = S_DONE;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_ptr = f_next(r_ptr);
                    n_iss = r_iss + 1'b1;
                end
                n_pend = issue;
                if (r_pend && (i_mem_rdata == r_tid)) begin
                    n_status = ST_DUPLICATE;
                    n_state  = S_DONE;
                end else if (r_pend && !issue) begin
                    if (r_occ == OCC_W'(QUEUE_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        o_mem_we = 1'b1;
                        n_tail   = f_next(r_tail);
                        n_occ    = r_occ + 1'b1;
                        n_status = ST_QUEUED;
                    end
                    n_state = S_DONE;
                end
            end
            S_WAKE: begin
                n_woken  = i_mem_rdata;
                n_head   = f_next(r_head);
                n_occ    = r_occ - 1'b1;
                n_status = ST_WOKEN;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_iss   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_iss   <= n_iss;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_tid    <= n_tid;
        r_status <= n_status;
        r_woken  <= n_woken;
    end

    assign o_done         = (r_state == S_DONE);
    assign o_status       = r_status;
    assign o_woken_thread = r_woken;
    assign o_count_now    = r_count;
    assign o_waiters_now  = r_occ;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(QUEUE_DEPTH))
        else $error("waiter count above queue depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !idle)
        else $error("accepted transaction left sequencer idle");

    a_wake_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAKE) |=> (r_occ == $past(r_occ) - 1'b1) && (r_status == ST_WOKEN))
        else $error("wake did not pop one waiter");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && i_out_free) |=> idle)
        else $error("result handoff did not return to idle");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_iss <= r_occ))
        else $error("scan issued past occupancy");

endmodule

// File: rtl/counting_semaphore_fifo_waitq.sv
// Counting semaphore with FIFO wait queue: top level, output register.
// Path to o_out_valid: grant, raise, saturate, or queue on an empty queue pass S_DONE and the
// output register; wake adds S_WAKE; down on a nonempty queue adds S_SCAN (one entry compared per
// cycle through the single read port of the wait memory, until a duplicate or the queue's end).
// The next transaction is accepted once the result is handed off.
// Reset: count 0, queue empty; wait memory contents are not cleared.
module counting_semaphore_fifo_waitq
    import csfw_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8,
    parameter int COUNT_BITS     = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_cmd,
    input  logic [THREAD_ID_BITS-1:0]            i_requester_thread,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [2:0]                           o_status,
    output logic [THREAD_ID_BITS-1:0]            o_woken_thread,
    output logic [COUNT_BITS-1:0]                o_count_now,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     o_waiters_now,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [CFG_BITS-1:0]                  i_cfg_initial_count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic                      out_free;
    logic                      done;
    t_status                   res_status;
    logic [THREAD_ID_BITS-1:0] res_woken;
    logic [COUNT_BITS-1:0]     res_count;
    logic [OCC_W-1:0]          res_occ;
    logic                      mem_we;
    logic [PTR_W-1:0]          mem_waddr;
    logic [THREAD_ID_BITS-1:0] mem_wdata;
    logic [PTR_W-1:0]          mem_raddr;
    logic [THREAD_ID_BITS-1:0] mem_rdata;

    logic                      r_out_valid;
    t_status                   r_out_status;
    logic [THREAD_ID_BITS-1:0] r_out_woken;
    logic [COUNT_BITS-1:0]     r_out_count;
    logic [OCC_W-1:0]          r_out_occ;

    assign out_free = ~r_out_valid | ~i_out_stall;

    csfw_ctrl #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .THREAD_ID_BITS(THREAD_ID_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_cmd              (i_cmd),
        .i_requester_thread (i_requester_thread),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_initial_count(i_cfg_initial_count),
        .i_out_free         (out_free),
        .o_done             (done),
        .o_status           (res_status),
        .o_woken_thread     (res_woken),
        .o_count_now        (res_count),
        .o_waiters_now      (res_occ),
        .o_mem_we           (mem_we),
        .o_mem_waddr        (mem_waddr),
        .o_mem_wdata        (mem_wdata),
        .o_mem_raddr        (mem_raddr),
        .i_mem_rdata        (mem_rdata)
    );

    csfw_wait_mem #(
        .DEPTH(QUEUE_DEPTH),
        .WIDTH(THREAD_ID_BITS)
    ) u_wait_mem (
        .i_clk    (i_clk),
        .i_wr_en  (mem_we),
        .i_wr_addr(mem_waddr),
        .i_wr_data(mem_wdata),
        .i_rd_addr(mem_raddr),
        .o_rd_data(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && done) begin
            r_out_status <= res_status;
            r_out_woken  <= res_woken;
            r_out_count  <= res_count;
            r_out_occ    <= res_occ;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_woken_thread = r_out_woken;
    assign o_count_now    = r_out_count;
    assign o_waiters_now  = r_out_occ;

endmodule

// File: sim/csfw_checker.sv
`timescale 1ns / 100ps
// Checker: predicts each semaphore result from the accepted transactions and compares.
module csfw_checker
    import csfw_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8,
    parameter int COUNT_BITS     = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic                               i_cmd,
    input  logic [THREAD_ID_BITS-1:0]          i_requester_thread,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [2:0]                         i_status,
    input  logic [THREAD_ID_BITS-1:0]          i_woken_thread,
    input  logic [COUNT_BITS-1:0]              i_count_now,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_waiters_now,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [CFG_BITS-1:0]                i_cfg_initial_count,
    output int                                 o_outstanding,
    output int                                 o_fail_count
);

    localparam int WAIT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef struct packed {
        t_status                   status;
        logic [THREAD_ID_BITS-1:0] woken;
        logic [COUNT_BITS-1:0]     count;
        logic [WAIT_BITS-1:0]      waiters;
    } t_sem_result;

    logic [COUNT_BITS-1:0]     avail;
    logic [THREAD_ID_BITS-1:0] wait_ids [QUEUE_DEPTH];
    int unsigned               head;
    int unsigned               tail;
    logic [WAIT_BITS-1:0]      occupancy;
    t_sem_result               results_due [$];
    int                        fails = 0;

    function automatic void reload_semaphore(input logic [CFG_BITS-1:0] init_count);
        avail     = (init_count > CNT_MAX) ? CNT_MAX : init_count;
        head      = 0;
        tail      = 0;
        occupancy = '0;
    endfunction

    function automatic t_sem_result predict_semaphore(input t_cmd op,
                                                      input logic [THREAD_ID_BITS-1:0] tid);
        t_sem_result r;
        bit          queued_already;
        r.woken = '0;
        if (op == CMD_DOWN) begin
            queued_already = 1'b0;
            for (int i = 0; i < occupancy; i++) begin
                if (wait_ids[(head + i) % QUEUE_DEPTH] == tid) begin
                    queued_already = 1'b1;
                end
            end
            if (avail != '0) begin
                avail    = avail - 1'b1;
                r.status = ST_GRANTED;
            end else if (queued_already) begin
                r.status = ST_DUPLICATE;
            end else if (occupancy >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                wait_ids[tail] = tid;
                tail           = (tail + 1) % QUEUE_DEPTH;
                occupancy      = occupancy + 1'b1;
                r.status       = ST_QUEUED;
            end
        end else begin
            if (occupancy != '0) begin
                r.woken   = wait_ids[head];
                head      = (head + 1) % QUEUE_DEPTH;
                occupancy = occupancy - 1'b1;
                r.status  = ST_WOKEN;
            end else if (avail == CNT_MAX) begin
                r.status = ST_SATURATED;
            end else begin
                avail    = avail + 1'b1;
                r.status = ST_RAISED;
            end
        end
        r.count   = avail;
        r.waiters = occupancy;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sem_result want;
        if (!i_rst_n) begin
            reload_semaphore('0);
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                reload_semaphore(i_cfg_initial_count);
            end
            if (i_in_valid && !i_in_stall) begin
                results_due.push_back(predict_semaphore(t_cmd'(i_cmd), i_requester_thread));
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result transaction: status %0d", i_status);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    if (want.status != t_status'(i_status)) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fails++;
                    end
                    if (want.woken != i_woken_thread) begin
                        $error("woken_thread: expected %0d, actual %0d",
                               want.woken, i_woken_thread);
                        fails++;
                    end
                    if (want.count != i_count_now) begin
                        $error("count_now: expected %0d, actual %0d", want.count, i_count_now);
                        fails++;
                    end
                    if (want.waiters != i_waiters_now) begin
                        $error("waiters_now: expected %0d, actual %0d",
                               want.waiters, i_waiters_now);
                        fails++;
                    end
                end
            end
        end
        o_outstanding <= results_due.size();
        o_fail_count  <= fails;
    end

endmodule

// File: sim/counting_semaphore_fifo_waitq_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives semaphore requests and register writes, reports the verdict.
module counting_semaphore_fifo_waitq_tb;
    import csfw_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int THREAD_ID_BITS = 8;
    localparam int COUNT_BITS     = 8;
    localparam int WAIT_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int PHASE_ITEMS    = 172;
    localparam int LIMIT_CYCLES   = 800000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      cmd = CMD_DOWN;
    logic [THREAD_ID_BITS-1:0] requester_thread = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [2:0]                status;
    logic [THREAD_ID_BITS-1:0] woken_thread;
    logic [COUNT_BITS-1:0]     count_now;
    logic [WAIT_BITS-1:0]      waiters_now;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_BITS-1:0]       cfg_initial_count = '0;
    int                        outstanding;
    int                        fail_count;
    bit                        quiet = 1'b0;
    int unsigned               stall_left = 0;

    counting_semaphore_fifo_waitq #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .THREAD_ID_BITS(THREAD_ID_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_cmd              (cmd),
        .i_requester_thread (requester_thread),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_status           (status),
        .o_woken_thread     (woken_thread),
        .o_count_now        (count_now),
        .o_waiters_now      (waiters_now),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_initial_count(cfg_initial_count)
    );

    csfw_checker #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .THREAD_ID_BITS(THREAD_ID_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_cmd              (cmd),
        .i_requester_thread (requester_thread),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_status           (status),
        .i_woken_thread     (woken_thread),
        .i_count_now        (count_now),
        .i_waiters_now      (waiters_now),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_initial_count(cfg_initial_count),
        .o_outstanding      (outstanding),
        .o_fail_count       (fail_count)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // random result-side back-pressure in bursts
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 17);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    task automatic send_request(input t_cmd op, input logic [THREAD_ID_BITS-1:0] tid);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        cmd              <= op;
        requester_thread <= tid;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_initial_count(input logic [CFG_BITS-1:0] value);
        wait_drained();
        cfg_valid         <= 1'b1;
        cfg_initial_count <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_BITS-1:0] init_count, input int down_pct,
                             input int tid_span);
        t_cmd                      op;
        logic [THREAD_ID_BITS-1:0] tid;
        write_initial_count(init_count);
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            op  = ($urandom_range(0, 99) < down_pct) ? CMD_DOWN : CMD_UP;
            tid = ($urandom_range(0, 3) == 0) ? THREAD_ID_BITS'($urandom_range(0, 255))
                                              : THREAD_ID_BITS'($urandom_range(0, tid_span));
            send_request(op, tid);
            if (k == PHASE_ITEMS / 2) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // count starts at zero: raise, grant, queue, duplicate, wake
        send_request(CMD_UP, 8'd0);
        send_request(CMD_DOWN, 8'd255);
        send_request(CMD_DOWN, 8'd0);
        send_request(CMD_DOWN, 8'd0);
        send_request(CMD_UP, 8'd255);

        // top count: saturate, then grant
        write_initial_count(8'd255);
        send_request(CMD_UP, 8'd0);
        send_request(CMD_DOWN, 8'd1);

        // fill the queue, then full, duplicate ahead of full, wake
        write_initial_count(8'd0);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            send_request(CMD_DOWN, 8'((15 - i) * 17));
        end
        send_request(CMD_DOWN, 8'd77);
        send_request(CMD_DOWN, 8'd170);
        send_request(CMD_UP, 8'd0);

        run_phase(8'd0, 70, 15);
        run_phase(8'd255, 30, 255);
        run_phase(8'd1, 55, 7);
        run_phase(8'd254, 40, 255);
        run_phase(8'd0, 80, 20);
        run_phase(8'd2, 60, 3);
        run_phase(8'($urandom_range(0, 255)), 50, 31);
        run_phase(8'd0, 65, 17);
        run_phase(8'd253, 35, 255);
        quiet = 1'b1;
        run_phase(8'($urandom_range(0, 15)), 60, 12);

        wait_drained();
        repeat (QUEUE_DEPTH + 8) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/csfw_pkg.sv
rtl/csfw_wait_mem.sv
rtl/csfw_ctrl.sv
rtl/counting_semaphore_fifo_waitq.sv
sim/csfw_checker.sv
sim/counting_semaphore_fifo_waitq_tb.sv
